[rtl/tmr_pkg.sv]
// Shared types and constants for the timer bank.
// Used by tmr_alu, tmr_bank and multi_slot_software_timer_core.
`timescale 1ns / 1ps

package tmr_pkg;

   // Bank geometry
   localparam int NUM_TIMERS = 8;
   localparam int SLOT_W     = 3;
   localparam int TIME_W     = 32;
   localparam int MASK_W     = 8;

   // Request opcodes
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_STOP    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   // Response kinds
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_EXPIRE = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_ACK,
      ST_TCHK,
      ST_TADV,
      ST_EMIT
   } state_type;

   // Slot bank write request
   typedef struct packed {
      logic              we_deadline;
      logic              we_interval;
      logic              we_periodic;
      logic              set_active;
      logic              clr_active;
      logic [SLOT_W-1:0] idx;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] interval;
      logic              periodic;
   } bank_wr_type;

   // Slot bank read data at the current address
   typedef struct packed {
      logic              active;
      logic              periodic;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] deadline;
   } bank_rd_type;

endpackage

[rtl/multi_slot_software_timer_core.sv]
// Timer bank top level: sequencer around one shared add/subtract unit.
// Start/stop/restart: the request passes ST_CMD, then ST_ACK registers the ack; the next
// request is taken back in ST_IDLE. Tick: ST_TCHK checks each slot in turn, with an ST_TADV
// step after each due periodic slot, then ST_EMIT scans slot indices up to the last due slot.
// Output stalls hold ST_ACK and ST_EMIT. Synchronous active-high reset clears all slot state.
// Depends on tmr_pkg, tmr_alu, tmr_bank.
`timescale 1ns / 1ps

module multi_slot_software_timer_core
   import tmr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [TIME_W-1:0] req_interval,
   input  logic              req_repeat_mode,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [SLOT_W-1:0] rsp_expired_slot,
   output logic [MASK_W-1:0] rsp_active_mask,
   output logic              rsp_last
);

   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [TIME_W-1:0]     ivl_ff, ivl_in;
   logic                  rep_ff, rep_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [NUM_TIMERS-1:0] due_ff, due_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  kind_ff, kind_in;
   logic [SLOT_W-1:0]     oslot_ff, oslot_in;
   logic [MASK_W-1:0]     omask_ff, omask_in;
   logic                  olast_ff, olast_in;

   logic [TIME_W-1:0]     alu_a, alu_b, alu_y;
   logic                  alu_sub, alu_neg;
   logic [SLOT_W-1:0]     bank_idx;
   bank_rd_type           bank_rd;
   bank_wr_type           bank_wr;
   logic [MASK_W-1:0]     mask;
   logic                  out_free;
   logic                  slot_ok;
   logic                  walk_done;
   logic                  more_due;

   tmr_alu u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .sub      (alu_sub),
      .result   (alu_y),
      .negative (alu_neg)
   );

   tmr_bank u_bank (
      .clock       (clock),
      .reset       (reset),
      .rd_idx      (bank_idx),
      .rd_data     (bank_rd),
      .wr          (bank_wr),
      .active_mask (mask)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_ok   = (32'(slot_ff) < NUM_TIMERS);
   assign walk_done = (idx_ff == SLOT_W'(NUM_TIMERS - 1));
   assign more_due  = |((due_ff >> idx_ff) >> 1);
   assign bank_idx  = (state_ff == ST_TCHK || state_ff == ST_TADV) ? idx_ff : slot_ff;

   // Sequencer: next state, datapath control and output register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      ivl_in       = ivl_ff;
      rep_in       = rep_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      due_in       = due_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      oslot_in     = oslot_ff;
      omask_in     = omask_ff;
      olast_in     = olast_ff;

      alu_a   = now_ff;
      alu_b   = bank_rd.deadline;
      alu_sub = 1'b1;

      bank_wr          = '0;
      bank_wr.idx      = bank_idx;
      bank_wr.deadline = alu_y;
      bank_wr.interval = ivl_ff;
      bank_wr.periodic = rep_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               slot_in = req_slot;
               ivl_in = req_interval;
               rep_in = req_repeat_mode;
               now_in = req_now;
               idx_in = '0;
               due_in = '0;
               state_in = (req_op == OP_TICK) ? ST_TCHK : ST_CMD;
            end
         end

         // Command update: start/restart set deadline = now + interval, stop clears active
         ST_CMD: begin
            alu_a   = now_ff;
            alu_b   = (op_ff == OP_START) ? ivl_ff : bank_rd.interval;
            alu_sub = 1'b0;
            if (slot_ok) begin
               case (op_ff)
                  OP_START: begin
                     bank_wr.we_interval = 1'b1;
                     bank_wr.we_periodic = 1'b1;
                     bank_wr.we_deadline = 1'b1;
                     bank_wr.set_active  = 1'b1;
                  end
                  OP_STOP: begin
                     bank_wr.clr_active = 1'b1;
                  end
                  OP_RESTART: begin
                     bank_wr.we_deadline = 1'b1;
                     bank_wr.set_active  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            state_in = ST_ACK;
         end

         // Acknowledge with the updated mask
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_ACK;
               oslot_in     = slot_ff;
               omask_in     = mask;
               olast_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // Due check: sign of (now - deadline)
         ST_TCHK: begin
            alu_a   = now_ff;
            alu_b   = bank_rd.deadline;
            alu_sub = 1'b1;
            if (bank_rd.active && !alu_neg) begin
               due_in[idx_ff] = 1'b1;
            end
            if (bank_rd.active && !alu_neg && bank_rd.periodic) begin
               state_in = ST_TADV;
            end else begin
               if (bank_rd.active && !alu_neg) begin
                  bank_wr.clr_active = 1'b1;
               end
               if (walk_done) begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         // Periodic advance: deadline += interval
         ST_TADV: begin
            alu_a   = bank_rd.deadline;
            alu_b   = bank_rd.interval;
            alu_sub = 1'b0;
            bank_wr.we_deadline = 1'b1;
            if (walk_done) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TCHK;
            end
         end

         // Emit one expiry per due slot, ascending
         ST_EMIT: begin
            if (due_ff == '0) begin
               state_in = ST_IDLE;
            end else if (due_ff[idx_ff]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_EXPIRE;
                  oslot_in     = idx_ff;
                  omask_in     = mask;
                  olast_in     = !more_due;
                  if (more_due) begin
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         due_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         due_ff       <= due_in;
      end
   end

   // Request and response payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      slot_ff  <= slot_in;
      ivl_ff   <= ivl_in;
      rep_ff   <= rep_in;
      now_ff   <= now_in;
      kind_ff  <= kind_in;
      oslot_ff <= oslot_in;
      omask_ff <= omask_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_expired_slot = oslot_ff;
   assign rsp_active_mask  = omask_ff;
   assign rsp_last         = olast_ff;

endmodule

[rtl/tmr_alu.sv]
// Shared 32-bit add/subtract unit for the timer bank.
// Depends on tmr_pkg.
`timescale 1ns / 1ps

module tmr_alu
   import tmr_pkg::*;
(
   input  logic [TIME_W-1:0] op_a,
   input  logic [TIME_W-1:0] op_b,
   input  logic              sub,
   output logic [TIME_W-1:0] result,
   output logic              negative
);

   // Modulo 2^32 add or subtract; sign bit used for wrap-safe compare
   always_comb begin
      if (sub) begin
         result = op_a - op_b;
      end else begin
         result = op_a + op_b;
      end
      negative = result[TIME_W-1];
   end

endmodule

[rtl/tmr_bank.sv]
// Slot state storage: active, periodic, interval and deadline per slot.
// Depends on tmr_pkg.
`timescale 1ns / 1ps

module tmr_bank
   import tmr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_idx,
   output bank_rd_type       rd_data,
   input  bank_wr_type       wr,
   output logic [MASK_W-1:0] active_mask
);

   logic [NUM_TIMERS-1:0] active_ff;
   logic [NUM_TIMERS-1:0] active_in;
   logic [NUM_TIMERS-1:0] periodic_ff;
   logic [NUM_TIMERS-1:0] periodic_in;
   logic [TIME_W-1:0]     interval_ff [NUM_TIMERS];
   logic [TIME_W-1:0]     interval_in [NUM_TIMERS];
   logic [TIME_W-1:0]     deadline_ff [NUM_TIMERS];
   logic [TIME_W-1:0]     deadline_in [NUM_TIMERS];

   // Single write port
   always_comb begin
      active_in   = active_ff;
      periodic_in = periodic_ff;
      interval_in = interval_ff;
      deadline_in = deadline_ff;
      if (wr.set_active) begin
         active_in[wr.idx] = 1'b1;
      end
      if (wr.clr_active) begin
         active_in[wr.idx] = 1'b0;
      end
      if (wr.we_periodic) begin
         periodic_in[wr.idx] = wr.periodic;
      end
      if (wr.we_interval) begin
         interval_in[wr.idx] = wr.interval;
      end
      if (wr.we_deadline) begin
         deadline_in[wr.idx] = wr.deadline;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         periodic_ff <= '0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            interval_ff[i] <= '0;
            deadline_ff[i] <= '0;
         end
      end else begin
         active_ff   <= active_in;
         periodic_ff <= periodic_in;
         interval_ff <= interval_in;
         deadline_ff <= deadline_in;
      end
   end

   // Single read address
   always_comb begin
      rd_data.active   = active_ff[rd_idx];
      rd_data.periodic = periodic_ff[rd_idx];
      rd_data.interval = interval_ff[rd_idx];
      rd_data.deadline = deadline_ff[rd_idx];
   end

   assign active_mask = MASK_W'(active_ff);

endmodule

[test/tb_top.sv]
// Self-checking bench for multi_slot_software_timer_core: directed table, then random requests.
// Expected responses come from an in-bench model of the eight timer slots.
// Depends on tmr_pkg and the timer bank RTL.
`timescale 1ns / 1ps

module tb_top;
   import tmr_pkg::*;

   // Response fields as seen on the rsp_ port group
   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [MASK_W-1:0] mask;
      logic              last;
   } timer_rsp_type;

   // One request; chk marks rows whose response is typed in by hand
   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] interval;
      logic              rep;
      logic [TIME_W-1:0] now;
      logic              chk;
      logic              exp_n;
      timer_rsp_type     exp;
   } timer_req_type;

   typedef struct {
      bit            typed;
      bit            n;
      timer_rsp_type rsp;
   } hand_check_type;

   localparam int DIR_ROWS   = 25;
   localparam int RAND_ITEMS = 320;
   localparam int IDLE_PCT   = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_op = OP_TICK;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [TIME_W-1:0] req_interval = '0;
   logic              req_repeat_mode = 1'b0;
   logic [TIME_W-1:0] req_now = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [SLOT_W-1:0] rsp_expired_slot;
   logic [MASK_W-1:0] rsp_active_mask;
   logic              rsp_last;

   // Timer bank state as the model sees it
   bit                tm_active   [NUM_TIMERS];
   bit                tm_periodic [NUM_TIMERS];
   logic [TIME_W-1:0] tm_interval [NUM_TIMERS];
   logic [TIME_W-1:0] tm_deadline [NUM_TIMERS];

   timer_rsp_type  step_rsp[$];
   timer_rsp_type  pending_rsp[$];
   hand_check_type hand_check_q[$];
   int             fail_count = 0;
   int             requests_sent = 0;

   // Directed table: reset state, wraparound edges, zero interval, late ticks
   timer_req_type dir_rows [DIR_ROWS] = '{
      // stop after reset, then a tick with nothing armed
      '{OP_STOP,    3'd0, 32'd0,         1'b0, 32'd0,         1'b1, 1'b1,
        '{KIND_ACK, 3'd0, 8'h00, 1'b1}},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'd0,         1'b1, 1'b0, '0},
      // restart of a never-started slot: zero interval, one-shot, due at once
      '{OP_RESTART, 3'd7, 32'd0,         1'b0, 32'd0,         1'b1, 1'b1,
        '{KIND_ACK, 3'd7, 8'h80, 1'b1}},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'd0,         1'b1, 1'b1,
        '{KIND_EXPIRE, 3'd7, 8'h00, 1'b1}},
      // periodic zero interval; maximum interval across the wrap
      '{OP_START,   3'd0, 32'd0,         1'b1, 32'd5,         1'b1, 1'b1,
        '{KIND_ACK, 3'd0, 8'h01, 1'b1}},
      '{OP_START,   3'd1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{KIND_ACK, 3'd1, 8'h03, 1'b1}},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'd5,         1'b0, 1'b0, '0},
      // half-range distance reads as negative, so not yet due
      '{OP_START,   3'd3, 32'h8000_0000, 1'b0, 32'd0,         1'b1, 1'b1,
        '{KIND_ACK, 3'd3, 8'h09, 1'b1}},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'd0,         1'b0, 1'b0, '0},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'h8000_0000, 1'b0, 1'b0, '0},
      // late ticks advance a periodic slot one interval at a time
      '{OP_START,   3'd2, 32'd10,        1'b1, 32'd100,       1'b0, 1'b0, '0},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'd200,       1'b0, 1'b0, '0},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'd200,       1'b0, 1'b0, '0},
      '{OP_RESTART, 3'd2, 32'hFFFF_FFFF, 1'b0, 32'd300,       1'b0, 1'b0, '0},
      '{OP_START,   3'd4, 32'd1,         1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{OP_START,   3'd5, 32'h7FFF_FFFF, 1'b0, 32'h1234_5678, 1'b0, 1'b0, '0},
      '{OP_START,   3'd6, 32'd3,         1'b0, 32'd0,         1'b0, 1'b0, '0},
      '{OP_START,   3'd7, 32'd2,         1'b1, 32'd0,         1'b0, 1'b0, '0},
      '{OP_TICK,    3'd7, 32'hFFFF_FFFF, 1'b1, 32'd3,         1'b0, 1'b0, '0},
      // restart of an expired one-shot uses its stored interval
      '{OP_RESTART, 3'd6, 32'd0,         1'b1, 32'd10,        1'b0, 1'b0, '0},
      '{OP_STOP,    3'd0, 32'hFFFF_FFFF, 1'b1, 32'd0,         1'b0, 1'b0, '0},
      '{OP_STOP,    3'd4, 32'd0,         1'b0, 32'd0,         1'b0, 1'b0, '0},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{OP_TICK,    3'd0, 32'd0,         1'b0, 32'h0000_0040, 1'b0, 1'b0, '0}
   };

   multi_slot_software_timer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_interval     (req_interval),
      .req_repeat_mode  (req_repeat_mode),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_expired_slot (rsp_expired_slot),
      .rsp_active_mask  (rsp_active_mask),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("** multi_slot_software_timer_core: FAILED **");
      $finish;
   end

   // Mask of armed slots, low eight slots only
   function automatic logic [MASK_W-1:0] armed_mask();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++)
         if (tm_active[i]) m[i] = 1'b1;
      return m;
   endfunction

   // Apply one request to the slot model; fills step_rsp with what it causes
   function automatic void timer_bank_step(input logic [1:0] op, input logic [SLOT_W-1:0] slot,
                                           input logic [TIME_W-1:0] interval, input logic rep,
                                           input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] lag;
      int                due[$];
      logic [MASK_W-1:0] m;
      step_rsp.delete();
      if (op == OP_TICK) begin
         // scan in slot order, due when now - deadline is not negative
         for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++) begin
            if (tm_active[i]) begin
               lag = now - tm_deadline[i];
               if (!lag[TIME_W-1]) begin
                  if (tm_periodic[i]) tm_deadline[i] = tm_deadline[i] + tm_interval[i];
                  else tm_active[i] = 1'b0;
                  due.push_back(i);
               end
            end
         end
         m = armed_mask();
         foreach (due[k])
            step_rsp.push_back('{KIND_EXPIRE, SLOT_W'(due[k]), m, k == due.size() - 1});
      end else begin
         if (int'(slot) < NUM_TIMERS) begin
            case (op)
               OP_START: begin
                  tm_interval[slot] = interval;
                  tm_periodic[slot] = rep;
                  tm_deadline[slot] = now + interval;
                  tm_active[slot]   = 1'b1;
               end
               OP_STOP: begin
                  tm_active[slot] = 1'b0;
               end
               default: begin
                  tm_deadline[slot] = now + tm_interval[slot];
                  tm_active[slot]   = 1'b1;
               end
            endcase
         end
         step_rsp.push_back('{KIND_ACK, slot, armed_mask(), 1'b1});
      end
   endfunction

   // Request driver: directed table, then random traffic around a running wall-time value
   initial begin : drive_requests
      timer_req_type     row;
      logic [TIME_W-1:0] wall;
      int                roll;
      wall = $urandom;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         tm_active[i]   = 1'b0;
         tm_periodic[i] = 1'b0;
         tm_interval[i] = '0;
         tm_deadline[i] = '0;
      end
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int n = 0; n < DIR_ROWS + RAND_ITEMS; n++) begin
         if (n < DIR_ROWS) begin
            row = dir_rows[n];
         end else begin
            row = '0;
            roll = $urandom_range(99);
            if (roll < 30) row.op = OP_START;
            else if (roll < 40) row.op = OP_STOP;
            else if (roll < 55) row.op = OP_RESTART;
            else row.op = OP_TICK;
            row.slot = SLOT_W'($urandom_range(NUM_TIMERS - 1));
            row.rep  = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (row.op != OP_START) row.interval = $urandom;
            else if (roll < 70) row.interval = $urandom_range(40);
            else if (roll < 90) row.interval = $urandom_range(3);
            else row.interval = $urandom;
            // time mostly creeps forward; now and then jump near the wrap
            if ($urandom_range(99) < 3) wall = 32'hFFFF_FF00 + $urandom_range(255);
            if (row.op == OP_TICK) wall = wall + $urandom_range(12);
            row.now = ($urandom_range(99) < 10) ? $urandom : wall;
         end
         // random idle cycles, none in the quiet window
         while (!(requests_sent >= 120 && requests_sent < 220)
                && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         hand_check_q.push_back('{row.chk, row.exp_n, row.exp});
         req_valid       <= 1'b1;
         req_op          <= row.op;
         req_slot        <= row.slot;
         req_interval    <= row.interval;
         req_repeat_mode <= row.rep;
         req_now         <= row.now;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         requests_sent++;
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      // a late tick may still be scanning slots
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("** multi_slot_software_timer_core: PASSED **");
      else
         $display("** multi_slot_software_timer_core: FAILED **");
      $finish;
   end

   // Scoreboard: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      hand_check_type hc;
      timer_rsp_type  want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            timer_bank_step(req_op, req_slot, req_interval, req_repeat_mode, req_now);
            hc = hand_check_q.pop_front();
            if (hc.typed) begin
               if (hc.n) pending_rsp.push_back(hc.rsp);
            end else begin
               foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected response: kind %0d slot %0d mask %h last %0d",
                      rsp_kind, rsp_expired_slot, rsp_active_mask, rsp_last);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_expired_slot !== want.slot) begin
                  $error("expired_slot: expected %0d, got %0d", want.slot, rsp_expired_slot);
                  fail_count++;
               end
               if (rsp_active_mask !== want.mask) begin
                  $error("active_mask: expected %h, got %h", want.mask, rsp_active_mask);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         // random back-pressure, none in the quiet window
         rsp_ready <= (requests_sent >= 120 && requests_sent < 220)
                      || ($urandom_range(99) >= IDLE_PCT);
      end
   end

endmodule
